### rtl/cbp_pkg.sv
// Shared constants and register codes for the cubic Bezier point evaluator.
package cbp_pkg;

  // Configuration register file
  localparam int NUM_REGS = 8;
  localparam int IDX_BITS = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_CTRL1_X  = 3'd2,
    REG_CTRL1_Y  = 3'd3,
    REG_CTRL2_X  = 3'd4,
    REG_CTRL2_Y  = 3'd5,
    REG_FINISH_X = 3'd6,
    REG_FINISH_Y = 3'd7
  } cfg_reg_t;

  // Register stages from input to output: three for the weights, four for the blend
  localparam int WEIGHT_STAGES = 3;
  localparam int BLEND_STAGES  = 4;
  localparam int PIPE_STAGES   = WEIGHT_STAGES + BLEND_STAGES;

endpackage

### rtl/cbp_param_if.sv
// Request channel carrying one curve parameter per request.
interface cbp_param_if #(
  parameter int T_BITS = 17
);
  logic              valid;
  logic              ready;
  logic [T_BITS-1:0] param_t;

  modport source (output valid, output param_t, input ready);
  modport sink   (input valid, input param_t, output ready);
endinterface

### rtl/cbp_point_if.sv
// Result channel carrying one curve point per request.
interface cbp_point_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

### rtl/cbp_weights.sv
// Three-stage Bernstein weight generator: clamp, squares, cubes.
module cbp_weights #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [FRAC_BITS:0]                  param_t,
  output logic [3:0][3*FRAC_BITS:0]           weight
);

  localparam int TW = FRAC_BITS + 1;
  localparam int SW = 2 * FRAC_BITS + 1;
  localparam int WW = 3 * FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [TW-1:0]   t_sat;
  logic [TW-1:0]   t1, u1, t2;
  logic [SW-1:0]   tt, uu, ut;
  logic [2*TW-1:0] tt_full, uu_full, ut_full;
  logic [SW+TW-1:0] w0_full, w1_full, w2_full, w3_full;

  // Complement of the parameter against one
  function automatic logic [TW-1:0] t_one_minus(input logic [TW-1:0] t);
    return T_ONE - t;
  endfunction

  // Clamp a parameter beyond one to one
  assign t_sat = (param_t > T_ONE) ? T_ONE : param_t;

  // Stage 1: parameter and its complement
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t_sat;
      u1 <= T_ONE - t_sat;
    end
  end

  // Stage 2: second-order products, all bounded by one at scale 2^(2F)
  assign tt_full = t1 * t1;
  assign uu_full = u1 * u1;
  assign ut_full = u1 * t1;

  always_ff @(posedge clk) begin
    if (en) begin
      tt <= tt_full[SW-1:0];
      uu <= uu_full[SW-1:0];
      ut <= ut_full[SW-1:0];
      t2 <= t1;
    end
  end

  // Stage 3: cubes; the factor 3 of the inner weights is applied to the coordinates
  assign w0_full = uu * (t_one_minus(t2));
  assign w1_full = uu * t2;
  assign w2_full = ut * t2;
  assign w3_full = tt * t2;

  always_ff @(posedge clk) begin
    if (en) begin
      weight[0] <= w0_full[WW-1:0];
      weight[1] <= w1_full[WW-1:0];
      weight[2] <= w2_full[WW-1:0];
      weight[3] <= w3_full[WW-1:0];
    end
  end

endmodule

### rtl/cbp_blend.sv
// Four-stage weighted sum of one coordinate axis with round-half-up output.
module cbp_blend #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [3:0][3*FRAC_BITS:0]    weight,
  input  logic [COORD_BITS-1:0]        coord0,
  input  logic [COORD_BITS-1:0]        coord1,
  input  logic [COORD_BITS-1:0]        coord2,
  input  logic [COORD_BITS-1:0]        coord3,
  output logic signed [COORD_BITS-1:0] point
);

  localparam int WW    = 3 * FRAC_BITS + 1;
  localparam int SHIFT = 3 * FRAC_BITS;
  localparam int LO    = (WW + 1) / 2;
  localparam int HI    = WW - LO;
  localparam int CW    = COORD_BITS + 2;
  localparam int PLW   = LO + CW + 1;
  localparam int PHW   = HI + CW + 1;
  localparam int AW    = COORD_BITS + SHIFT + 2;
  localparam logic signed [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (SHIFT - 1);

  logic signed [CW-1:0]  cw [4];
  logic signed [PLW-1:0] plo [4];
  logic signed [PHW-1:0] phi [4];
  logic signed [AW-1:0]  term [4];
  logic signed [AW-1:0]  term_next [4];
  logic signed [AW-1:0]  s01, s23, total;

  // Widen coordinates; triple the two inner ones to carry the binomial factor
  always_comb begin
    cw[0] = CW'($signed(coord0));
    cw[1] = (CW'($signed(coord1)) <<< 1) + CW'($signed(coord1));
    cw[2] = (CW'($signed(coord2)) <<< 1) + CW'($signed(coord2));
    cw[3] = CW'($signed(coord3));
  end

  // Stage 4: split each weight in two halves, one narrow product each
  for (genvar i = 0; i < 4; i++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        plo[i] <= $signed({1'b0, weight[i][LO-1:0]}) * cw[i];
        phi[i] <= $signed({1'b0, weight[i][WW-1:LO]}) * cw[i];
      end
    end

    // Recombine the halves at full width
    always_comb begin
      term_next[i] = ($signed({{(AW-PHW){phi[i][PHW-1]}}, phi[i]}) <<< LO)
                   + $signed({{(AW-PLW){plo[i][PLW-1]}}, plo[i]});
    end
  end

  // Stage 5: full-width terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        term[i] <= term_next[i];
      end
    end
  end

  // Stage 6: pairwise sums
  always_ff @(posedge clk) begin
    if (en) begin
      s01 <= term[0] + term[1];
      s23 <= term[2] + term[3];
    end
  end

  // Stage 7: final sum, round half up, drop the fraction
  assign total = s01 + s23 + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      point <= total[SHIFT +: COORD_BITS];
    end
  end

endmodule

### rtl/cubic_bezier_point.sv
// Cubic Bezier point evaluator: top level with register file and pipeline control.
//
// Usage: write the four control points (start, ctrl1, ctrl2, finish; x and y,
// register indexes 0 to 7) through the write port while the block is idle.
// Each request on param_in carries one parameter t in unsigned Q1.FRAC_BITS, where
// 2^FRAC_BITS is one; values above one are clamped to one. Each request
// yields one point on point_out, rounded half up to an integer coordinate.
// The pipeline has seven register stages: three stages build the Bernstein weights,
// four stages multiply by the coordinates in split halves and sum the terms.
// Throughput is one request per cycle while point_out does not stall;
// the pipeline has no loop and no shared unit.
// A stall on point_out freezes every stage at once and drops ready on
// param_in in the same cycle, so nothing is lost or repeated; bubbles move
// on while the output register is empty. Reset clears all stage valid bits
// and sets every control point to zero; no clearing pass is needed.
module cubic_bezier_point #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cbp_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  cbp_param_if.sink                    param_in,
  cbp_point_if.source                  point_out
);

  logic [COORD_BITS-1:0]              regs [cbp_pkg::NUM_REGS];
  logic [cbp_pkg::PIPE_STAGES-1:0]    vld;
  logic                               en;
  logic [3:0][3*FRAC_BITS:0]          weight;
  logic signed [COORD_BITS-1:0]       px, py;

  // Advance everything when the output register is empty or being taken
  assign en             = !vld[cbp_pkg::PIPE_STAGES-1] || point_out.ready;
  assign param_in.ready = en;

  // Control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbp_pkg::NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cbp_pkg::cfg_reg_t'(cfg_index))
        cbp_pkg::REG_START_X:  regs[0] <= cfg_data;
        cbp_pkg::REG_START_Y:  regs[1] <= cfg_data;
        cbp_pkg::REG_CTRL1_X:  regs[2] <= cfg_data;
        cbp_pkg::REG_CTRL1_Y:  regs[3] <= cfg_data;
        cbp_pkg::REG_CTRL2_X:  regs[4] <= cfg_data;
        cbp_pkg::REG_CTRL2_Y:  regs[5] <= cfg_data;
        cbp_pkg::REG_FINISH_X: regs[6] <= cfg_data;
        cbp_pkg::REG_FINISH_Y: regs[7] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[cbp_pkg::PIPE_STAGES-2:0], param_in.valid};
    end
  end

  cbp_weights #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weights (
    .clk     (clk),
    .en      (en),
    .param_t (param_in.param_t),
    .weight  (weight)
  );

  cbp_blend #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_blend_x (
    .clk    (clk),
    .en     (en),
    .weight (weight),
    .coord0 (regs[0]),
    .coord1 (regs[2]),
    .coord2 (regs[4]),
    .coord3 (regs[6]),
    .point  (px)
  );

  cbp_blend #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_blend_y (
    .clk    (clk),
    .en     (en),
    .weight (weight),
    .coord0 (regs[1]),
    .coord1 (regs[3]),
    .coord2 (regs[5]),
    .coord3 (regs[7]),
    .point  (py)
  );

  // Result channel
  assign point_out.valid   = vld[cbp_pkg::PIPE_STAGES-1];
  assign point_out.point_x = px;
  assign point_out.point_y = py;

endmodule
